[sv/assert_macros.svh]
// Assertion helpers for the RTL files; the core file includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/dspg_pkg.sv]
`default_nettype none
package dspg_pkg;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

  typedef enum logic [2:0] {
    CFG_LEFT_PERIOD         = 3'd0,
    CFG_RIGHT_PERIOD        = 3'd1,
    CFG_LEFT_ENABLE         = 3'd2,
    CFG_RIGHT_ENABLE        = 3'd3,
    CFG_LEFT_REVERSE        = 3'd4,
    CFG_RIGHT_REVERSE       = 3'd5,
    CFG_LEFT_FORWARD_LEVEL  = 3'd6,
    CFG_RIGHT_FORWARD_LEVEL = 3'd7
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] period;
    logic        enable;
    logic        reverse;
    logic        fwd_level;
  } motor_cfg_t;

  typedef struct packed {
    logic               left_clock;
    logic               right_clock;
    logic               left_dir;
    logic               right_dir;
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic               window_done;
    logic signed [15:0] left_delta;
    logic signed [15:0] right_delta;
  } result_t;

  typedef struct packed {
    logic main_valid;
    logic skid_valid;
  } buf_status_t;

endpackage
`default_nettype wire

[sv/dspg_motor.sv]
`default_nettype none
module dspg_motor import dspg_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire motor_cfg_t         cfg,
  input  wire logic               step,
  input  wire logic               clear,
  output logic                    clock_next,
  output logic                    dir,
  output logic signed [31:0]      count_next,
  output logic        [15:0]      odo_next
);

  logic        [15:0] ticks, ticks_next;
  logic               clock_level;
  logic signed [31:0] steps;
  logic        [15:0] odo;
  logic signed [31:0] base;
  logic               fire;

  assign dir  = cfg.fwd_level ^ cfg.reverse;
  assign fire = cfg.enable && (cfg.period <= ticks);
  assign base = clear ? 32'sd0 : steps;

  always_comb begin
    clock_next = clock_level;
    count_next = base;
    odo_next   = odo;
    ticks_next = ticks;
    if (fire) begin
      clock_next = ~clock_level;
      ticks_next = '0;
      count_next = cfg.reverse ? base - 32'sd1 : base + 32'sd1;
      odo_next   = dir ? odo + 16'd1 : odo - 16'd1;
    end else if (ticks != TICKS_MAX) begin
      ticks_next = ticks + 16'd1;
    end
  end

  // Only the low half of the odometer is kept: the window delta needs no more.
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks       <= '0;
      clock_level <= 1'b0;
      steps       <= '0;
      odo         <= '0;
    end else if (step) begin
      ticks       <= ticks_next;
      clock_level <= clock_next;
      steps       <= count_next;
      odo         <= odo_next;
    end
  end

endmodule
`default_nettype wire

[sv/dspg_window.sv]
`default_nettype none
module dspg_window import dspg_pkg::*; #(
  parameter int WINDOW = 400
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire logic [15:0]        left_odo,
  input  wire logic [15:0]        right_odo,
  output logic                    done,
  output logic signed [15:0]      left_delta,
  output logic signed [15:0]      right_delta
);

  localparam int WinW = $clog2(WINDOW + 1);
  localparam logic [WinW-1:0] WinLast = WinW'(WINDOW);

  logic [WinW-1:0] window_ticks;
  logic [15:0]     left_last, right_last;

  assign done        = (window_ticks == WinLast);
  assign left_delta  = done ? signed'(left_odo - left_last) : 16'sd0;
  assign right_delta = done ? signed'(right_odo - right_last) : 16'sd0;

  // The counter never passes WINDOW, so it needs no wrap of its own.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= '0;
      left_last    <= '0;
      right_last   <= '0;
    end else if (step) begin
      if (done) begin
        window_ticks <= WinW'(1);
        left_last    <= left_odo;
        right_last   <= right_odo;
      end else begin
        window_ticks <= window_ticks + WinW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[sv/dspg_out_buf.sv]
`default_nettype none
module dspg_out_buf import dspg_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire result_t push_data,
  output logic         push_ready,
  output logic         pop_valid,
  input  wire logic    pop_ready,
  output result_t      pop_data,
  output buf_status_t  status
);

  logic    main_valid, skid_valid;
  result_t skid_data;
  logic    pop;
  logic    main_free;

  assign pop        = main_valid && pop_ready;
  assign main_free  = !main_valid || pop;
  assign push_ready = !skid_valid;
  assign pop_valid  = main_valid;
  assign status     = '{main_valid: main_valid, skid_valid: skid_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (main_free) begin
        main_valid <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // A waiting skid beat always moves ahead of a new one, keeping order.
  always_ff @(posedge clk) begin
    if (main_free) begin
      pop_data <= skid_valid ? skid_data : push_data;
    end
    if (push && !main_free) begin
      skid_data <= push_data;
    end
  end

endmodule
`default_nettype wire

[sv/dual_stepper_pulse_generator_core.sv]
// Step and direction pulse generator for two stepper motors.
// Each beat on the input channel (in_valid, in_ready, clear_counts) is one
// timer tick. Each tick yields exactly one result beat on the output channel
// (out_valid, out_ready and the result fields): clock and direction pin
// levels, both clearable step counts, and once every WINDOW ticks the
// odometer deltas flagged by window_done.
// All motor state is updated at the tick's accept edge and the result is
// registered there. One tick is taken every cycle while in_ready is high,
// set by the single pass through the tick compare and counter increments.
// A two-entry output buffer lets a tick be accepted while a result waits;
// in_ready falls only once two results are held, and rises again when the
// receiver takes one. Stalling never drops or repeats a result.
// The configuration registers are written through cfg_write, cfg_index and
// cfg_data with no wait; they are meant to change only while idle.
// Reset clears all counters and clock levels, empties the buffer, and sets
// the registers to zero except right_forward_level, which comes up high.
// The first window closes on tick WINDOW+1 after reset, later ones every
// WINDOW ticks.
`default_nettype none
`include "assert_macros.svh"
module dual_stepper_pulse_generator_core import dspg_pkg::*; #(
  parameter int WINDOW = 400
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               clear_counts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    left_clock,
  output logic                    right_clock,
  output logic                    left_dir,
  output logic                    right_dir,
  output logic signed [31:0]      left_count,
  output logic signed [31:0]      right_count,
  output logic                    window_done,
  output logic signed [15:0]      left_delta,
  output logic signed [15:0]      right_delta
);

  motor_cfg_t  left_cfg, right_cfg;
  logic        step;
  result_t     res, out_data;
  buf_status_t buf_status;
  logic [15:0] left_odo, right_odo;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_cfg  <= '{period: 16'd0, enable: 1'b0, reverse: 1'b0, fwd_level: 1'b0};
      right_cfg <= '{period: 16'd0, enable: 1'b0, reverse: 1'b0, fwd_level: 1'b1};
    end else if (cfg_write) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_LEFT_PERIOD:         left_cfg.period     <= cfg_data;
        CFG_RIGHT_PERIOD:        right_cfg.period    <= cfg_data;
        CFG_LEFT_ENABLE:         left_cfg.enable     <= cfg_data[0];
        CFG_RIGHT_ENABLE:        right_cfg.enable    <= cfg_data[0];
        CFG_LEFT_REVERSE:        left_cfg.reverse    <= cfg_data[0];
        CFG_RIGHT_REVERSE:       right_cfg.reverse   <= cfg_data[0];
        CFG_LEFT_FORWARD_LEVEL:  left_cfg.fwd_level  <= cfg_data[0];
        CFG_RIGHT_FORWARD_LEVEL: right_cfg.fwd_level <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign step = in_valid && in_ready;

  dspg_motor u_left (
    .clk        (clk),
    .rst        (rst),
    .cfg        (left_cfg),
    .step       (step),
    .clear      (clear_counts),
    .clock_next (res.left_clock),
    .dir        (res.left_dir),
    .count_next (res.left_count),
    .odo_next   (left_odo)
  );

  dspg_motor u_right (
    .clk        (clk),
    .rst        (rst),
    .cfg        (right_cfg),
    .step       (step),
    .clear      (clear_counts),
    .clock_next (res.right_clock),
    .dir        (res.right_dir),
    .count_next (res.right_count),
    .odo_next   (right_odo)
  );

  dspg_window #(.WINDOW(WINDOW)) u_window (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .left_odo    (left_odo),
    .right_odo   (right_odo),
    .done        (res.window_done),
    .left_delta  (res.left_delta),
    .right_delta (res.right_delta)
  );

  dspg_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_data  (res),
    .push_ready (in_ready),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_data),
    .status     (buf_status)
  );

  assign left_clock  = out_data.left_clock;
  assign right_clock = out_data.right_clock;
  assign left_dir    = out_data.left_dir;
  assign right_dir   = out_data.right_dir;
  assign left_count  = out_data.left_count;
  assign right_count = out_data.right_count;
  assign window_done = out_data.window_done;
  assign left_delta  = out_data.left_delta;
  assign right_delta = out_data.right_delta;

  `ASSERT_ALWAYS(a_skid_behind_main, buf_status.skid_valid |-> buf_status.main_valid, "skid beat held with empty main register")
  `ASSERT_CLK(a_push_shows, step && !buf_status.main_valid |=> out_valid, "accepted tick did not reach the output")
  `ASSERT_CLK(a_skid_holds, buf_status.skid_valid && !out_ready |=> buf_status.skid_valid, "skid beat lost while stalled")
  `ASSERT_CLK(a_window_spacing, step && res.window_done |=> !res.window_done, "window closed on two ticks running")

endmodule
`default_nettype wire
